[sv/lzs_pkg.sv]
// ---------------------------------------------------------------------------
// lzs_pkg: shared types and constants for the layer z-order stack
// Sizes, opcode and status codes, FSM states and the shift command that is
// broadcast to the slot cells.
// ---------------------------------------------------------------------------
package lzs_pkg;

  localparam int NUM_LAYERS = 256;
  localparam int LAYER_W    = $clog2(NUM_LAYERS);
  localparam int HGT_W      = LAYER_W + 1;
  localparam int REQ_W      = 10;
  localparam int CLAMP_W    = ((HGT_W > REQ_W) ? HGT_W : REQ_W) + 1;

  // two-level lowest-set search: groups of GRP_SZ, then across groups
  localparam int GRP_SZ  = 16;
  localparam int GRP_W   = $clog2(GRP_SZ);
  localparam int NUM_GRP = (NUM_LAYERS + GRP_SZ - 1) / GRP_SZ;
  localparam int PAD_W   = NUM_GRP * GRP_SZ;

  localparam int IN_W  = 24;
  localparam int OUT_W = 32;

  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_SET   = 2'd1;
  localparam logic [1:0] FN_FREE  = 2'd2;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_NO_FREE  = 2'd1;
  localparam logic [1:0] STS_NOT_USED = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CALC,
    ST_EXEC
  } lzs_state_t;

  // up: slots in (lo, hi] take their lower neighbor
  // dn: slots in [lo, hi) take their upper neighbor
  // ins: slot pos takes id
  typedef struct packed {
    logic               up;
    logic               dn;
    logic               ins;
    logic [LAYER_W-1:0] lo;
    logic [LAYER_W-1:0] hi;
    logic [LAYER_W-1:0] pos;
    logic [LAYER_W-1:0] id;
  } lzs_shift_t;

endpackage

[sv/layer_zorder_stack_core.sv]
// ---------------------------------------------------------------------------
// layer_zorder_stack_core: display layer stacking order
// Allocate, set height and free requests against a chain of slot cells.
// ---------------------------------------------------------------------------
// A request passes through the states in order: ST_IDLE registers the word
// as it is taken; in ST_LOOK each slot cell matches its stored layer
// against the addressed one while the first stage of the match and
// lowest-free searches registers; ST_CALC finishes those searches, clamps
// the height and plans the shift; in ST_EXEC the slot chain shifts by one
// place and the result word is loaded. The slot chain moves at most one
// place per slot in ST_EXEC, so a single shift serves however far a layer
// moves. A new word is taken once the previous one has reached the output
// register; a stalled output holds the block in ST_EXEC.
// No clearing pass follows reset: layer-use flags reset at once and the stack
// slots are only read at or below the top height.
module layer_zorder_stack_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // func[1:0], layer_id[9:2], requested_height[19:10], zero pad
  input  logic [lzs_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // status[1:0], result_layer[9:2], result_height[18:10], top_height[27:19]
  output logic [lzs_pkg::OUT_W-1:0] out_tdata
);
  import lzs_pkg::*;

  lzs_state_t state_r, state_nxt;
  logic       exec_go;

  logic [1:0]              in_func_r;
  logic [7:0]              in_id_r;
  logic signed [REQ_W-1:0] in_req_r;
  logic [LAYER_W-1:0]      lookup;

  logic signed [HGT_W-1:0] top_r;
  logic [NUM_LAYERS-1:0]   in_use_r;

  logic [LAYER_W-1:0]    slot_id [NUM_LAYERS];
  logic [NUM_LAYERS-1:0] hit_vec;
  logic                  hit_found, free_found;
  logic [LAYER_W-1:0]    hit_idx, free_idx;

  lzs_shift_t              shift_r, shift_nxt;
  logic signed [HGT_W-1:0] top_new_r, top_new_nxt;
  logic                    set_use_r, set_use_nxt, clr_use_r, clr_use_nxt;
  logic [LAYER_W-1:0]      use_idx_r, use_idx_nxt;
  logic [1:0]              res_status_r, res_status_nxt;
  logic [7:0]              res_layer_r, res_layer_nxt;
  logic signed [HGT_W-1:0] res_height_r, res_height_nxt;

  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_data_r;

  assign lookup = LAYER_W'(in_id_r);

  // ---- control ----
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    exec_go   = (state_r == ST_EXEC) && (!out_valid_r || out_tready);
  end

  always_comb begin
    case (state_r)
      ST_IDLE: state_nxt = in_tvalid ? ST_LOOK : ST_IDLE;
      ST_LOOK: state_nxt = ST_CALC;
      ST_CALC: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = exec_go ? ST_IDLE : ST_EXEC;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_func_r <= in_tdata[1:0];
      in_id_r   <= in_tdata[9:2];
      in_req_r  <= in_tdata[19:10];
    end
  end

  // ---- slot chain ----
  for (genvar k = 0; k < NUM_LAYERS; k++) begin : g_cell
    logic [LAYER_W-1:0] left_w, right_w;
    if (k == 0) begin : g_left_edge
      assign left_w = '0;
    end else begin : g_left
      assign left_w = slot_id[k-1];
    end
    if (k == NUM_LAYERS - 1) begin : g_right_edge
      assign right_w = '0;
    end else begin : g_right
      assign right_w = slot_id[k+1];
    end
    lzs_cell u_cell (
      .clk       (clk),
      .slot_idx  (LAYER_W'(k)),
      .go        (exec_go),
      .ctl       (shift_r),
      .top       (top_r),
      .left_id   (left_w),
      .right_id  (right_w),
      .lookup_id (lookup),
      .slot_id   (slot_id[k]),
      .hit       (hit_vec[k])
    );
  end

  lzs_find u_hit_find (
    .clk   (clk),
    .req   (hit_vec),
    .found (hit_found),
    .idx   (hit_idx)
  );

  lzs_find u_free_find (
    .clk   (clk),
    .req   (~in_use_r),
    .found (free_found),
    .idx   (free_idx)
  );

  // ---- plan (valid in ST_CALC) ----
  always_comb begin
    logic signed [HGT_W-1:0]   old_h, want_h;
    logic signed [CLAMP_W-1:0] want_w, lim_w;
    logic                      id_ok, layer_used;

    id_ok      = (int'(in_id_r) < NUM_LAYERS);
    layer_used = id_ok && in_use_r[lookup];
    old_h      = hit_found ? $signed({1'b0, hit_idx}) : '1;

    // a shown layer can not go above the current top
    lim_w  = (old_h >= 0) ? CLAMP_W'(top_r) : CLAMP_W'(top_r) + CLAMP_W'(1);
    want_w = CLAMP_W'(in_req_r);
    if (want_w > lim_w) begin
      want_w = lim_w;
    end
    if (want_w < CLAMP_W'(-1)) begin
      want_w = CLAMP_W'(-1);
    end
    want_h = HGT_W'(want_w);

    shift_nxt      = '0;
    shift_nxt.id   = lookup;
    top_new_nxt    = top_r;
    set_use_nxt    = 1'b0;
    clr_use_nxt    = 1'b0;
    use_idx_nxt    = lookup;
    res_status_nxt = STS_OK;
    res_layer_nxt  = '0;
    res_height_nxt = '1;

    case (in_func_r)
      FN_ALLOC: begin
        if (free_found) begin
          set_use_nxt   = 1'b1;
          use_idx_nxt   = free_idx;
          res_layer_nxt = 8'(free_idx);
        end else begin
          res_status_nxt = STS_NO_FREE;
        end
      end
      FN_SET: begin
        res_layer_nxt = in_id_r;
        if (!layer_used) begin
          res_status_nxt = STS_NOT_USED;
        end else begin
          res_height_nxt = want_h;
          if (old_h > want_h) begin
            if (want_h >= 0) begin
              // lower a shown layer: those in between move up
              shift_nxt.up  = 1'b1;
              shift_nxt.ins = 1'b1;
              shift_nxt.lo  = LAYER_W'(want_h);
              shift_nxt.hi  = LAYER_W'(old_h);
              shift_nxt.pos = LAYER_W'(want_h);
            end else begin
              // hide: close the gap
              shift_nxt.dn = 1'b1;
              shift_nxt.lo = LAYER_W'(old_h);
              shift_nxt.hi = LAYER_W'(top_r);
              top_new_nxt  = HGT_W'(top_r - 1);
            end
          end else if (old_h < want_h) begin
            if (old_h >= 0) begin
              shift_nxt.dn  = 1'b1;
              shift_nxt.ins = 1'b1;
              shift_nxt.lo  = LAYER_W'(old_h);
              shift_nxt.hi  = LAYER_W'(want_h);
              shift_nxt.pos = LAYER_W'(want_h);
            end else begin
              // show: open a gap
              shift_nxt.up  = 1'b1;
              shift_nxt.ins = 1'b1;
              shift_nxt.lo  = LAYER_W'(want_h);
              shift_nxt.hi  = LAYER_W'(top_r + 1);
              shift_nxt.pos = LAYER_W'(want_h);
              top_new_nxt   = HGT_W'(top_r + 1);
            end
          end
        end
      end
      FN_FREE: begin
        res_layer_nxt = in_id_r;
        if (!layer_used) begin
          res_status_nxt = STS_NOT_USED;
        end else begin
          clr_use_nxt = 1'b1;
          if (old_h >= 0) begin
            shift_nxt.dn = 1'b1;
            shift_nxt.lo = LAYER_W'(old_h);
            shift_nxt.hi = LAYER_W'(top_r);
            top_new_nxt  = HGT_W'(top_r - 1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CALC) begin
      shift_r      <= shift_nxt;
      top_new_r    <= top_new_nxt;
      set_use_r    <= set_use_nxt;
      clr_use_r    <= clr_use_nxt;
      use_idx_r    <= use_idx_nxt;
      res_status_r <= res_status_nxt;
      res_layer_r  <= res_layer_nxt;
      res_height_r <= res_height_nxt;
    end
  end

  // ---- commit ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r    <= '1;
      in_use_r <= '0;
    end else if (exec_go) begin
      top_r <= top_new_r;
      if (set_use_r) begin
        in_use_r[use_idx_r] <= 1'b1;
      end else if (clr_use_r) begin
        in_use_r[use_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_data_r <= {4'b0, 9'(top_new_r), 9'(res_height_r), res_layer_r, res_status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[sv/lzs_cell.sv]
// ---------------------------------------------------------------------------
// lzs_cell: one slot of the stack
// Holds the layer shown at its height, shifts from a neighbor or loads the
// inserted layer, and flags a match against the looked-up layer.
// ---------------------------------------------------------------------------
module lzs_cell (
  input  logic                               clk,
  input  logic [lzs_pkg::LAYER_W-1:0]        slot_idx,
  input  logic                               go,
  input  lzs_pkg::lzs_shift_t                ctl,
  input  logic signed [lzs_pkg::HGT_W-1:0]   top,
  input  logic [lzs_pkg::LAYER_W-1:0]        left_id,
  input  logic [lzs_pkg::LAYER_W-1:0]        right_id,
  input  logic [lzs_pkg::LAYER_W-1:0]        lookup_id,
  output logic [lzs_pkg::LAYER_W-1:0]        slot_id,
  output logic                               hit
);
  import lzs_pkg::*;

  logic [LAYER_W-1:0] slot_r, slot_nxt;
  logic               take_left, take_right, put_here, shown;

  always_comb begin
    take_left  = ctl.up && (slot_idx > ctl.lo) && (slot_idx <= ctl.hi);
    take_right = ctl.dn && (slot_idx >= ctl.lo) && (slot_idx < ctl.hi);
    put_here   = ctl.ins && (slot_idx == ctl.pos);
    slot_nxt   = slot_r;
    if (go) begin
      if (put_here) begin
        slot_nxt = ctl.id;
      end else if (take_left) begin
        slot_nxt = left_id;
      end else if (take_right) begin
        slot_nxt = right_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  // slots above top hold stale ids
  assign shown   = !top[HGT_W-1] && (slot_idx <= top[LAYER_W-1:0]);
  assign hit     = shown && (slot_r == lookup_id);
  assign slot_id = slot_r;

endmodule

[sv/lzs_find.sv]
// ---------------------------------------------------------------------------
// lzs_find: lowest set bit search
// Group stage registered, group select combinational after it; result is
// valid in the cycle after the request vector.
// ---------------------------------------------------------------------------
module lzs_find (
  input  logic                              clk,
  input  logic [lzs_pkg::NUM_LAYERS-1:0]    req,
  output logic                              found,
  output logic [lzs_pkg::LAYER_W-1:0]       idx
);
  import lzs_pkg::*;

  logic [PAD_W-1:0]   req_pad;
  logic [NUM_GRP-1:0] grp_any_nxt, grp_any_r;
  logic [GRP_W-1:0]   grp_sub_nxt [NUM_GRP];
  logic [GRP_W-1:0]   grp_sub_r   [NUM_GRP];

  always_comb begin
    req_pad = '0;
    req_pad[NUM_LAYERS-1:0] = req;
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_any_nxt[g] = |req_pad[g*GRP_SZ +: GRP_SZ];
      grp_sub_nxt[g] = '0;
      for (int s = GRP_SZ - 1; s >= 0; s--) begin
        if (req_pad[g*GRP_SZ + s]) begin
          grp_sub_nxt[g] = GRP_W'(s);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any_r <= grp_any_nxt;
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_sub_r[g] <= grp_sub_nxt[g];
    end
  end

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        found = 1'b1;
        idx   = LAYER_W'(g * GRP_SZ + int'(grp_sub_r[g]));
      end
    end
  end

endmodule

[sv/lzs_checker.sv]
// ---------------------------------------------------------------------------
// lzs_checker: port-level checks for layer_zorder_stack_core
// Watches the stream ports and is bound to the top level.
// ---------------------------------------------------------------------------
module lzs_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [lzs_pkg::OUT_W-1:0] out_tdata
);
  import lzs_pkg::*;

  logic [1:0] out_status;
  assign out_status = out_tdata[1:0];

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // one request in flight: a word taken closes the input side
  a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_status == STS_OK || out_status == STS_NO_FREE ||
                    out_status == STS_NOT_USED))
    else $error("bad status code");

  a_fail_hidden : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_status != STS_OK |-> out_tdata[18:10] == 9'h1FF)
    else $error("failed request reports a height");

endmodule

bind layer_zorder_stack_core lzs_checker u_lzs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
